>>> rtl/slfa_pkg.sv
// Shared types, constants and codes of the slab free-list id allocator.
package slfa_pkg;

    localparam int ID_W       = 12;
    localparam int SLOT_W     = 8;
    localparam int SLOT_SIZE  = 256;
    localparam int MAX_SLOTS  = 16;
    localparam int ID_SPACE   = 4096;
    localparam int NSLOT_W    = ID_W - SLOT_W + 1;
    localparam int SLOT_CAP   = (MAX_SLOTS < ID_SPACE / SLOT_SIZE) ?
                                MAX_SLOTS : ID_SPACE / SLOT_SIZE;

    localparam int CFG_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int LIMIT_W    = 5;

    localparam logic [CFG_ADDR_W-1:0] ADDR_SLOT_LIMIT = CFG_ADDR_W'(0);

    typedef enum logic [1:0] {
        OP_ALLOC     = 2'd0,
        OP_FREE_HEAD = 2'd1,
        OP_FREE_TAIL = 2'd2,
        OP_LOOKUP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_OUTSIDE   = 2'd2,
        ST_NOT_ALLOC = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_EXEC  = 2'd2
    } t_state;

    typedef struct packed {
        logic            rd_en;
        logic [ID_W-1:0] rd_addr;
        logic            wr_en;
        logic [ID_W-1:0] wr_addr;
    } t_mem_ctl;

endpackage

>>> rtl/slfa_ifs.sv
// Request and response channel interfaces of the allocator.
interface slfa_req_if;
    logic                    valid;
    logic                    ready;
    logic [1:0]              op;
    logic [slfa_pkg::ID_W-1:0] node_id;

    modport source (output valid, output op, output node_id, input ready);
    modport sink   (input valid, input op, input node_id, output ready);
endinterface

interface slfa_rsp_if;
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic [slfa_pkg::ID_W-1:0] result_id;

    modport source (output valid, output status, output result_id, input ready);
    modport sink   (input valid, input status, input result_id, output ready);
endinterface

>>> rtl/slab_free_list_id_allocator.sv
// Slab free-list id allocator top level.
// Hands out 12-bit node ids from a linked free list held in a 4096-entry link
// memory, with a 4096-entry mark memory recording which ids are allocated. Ids
// come in slots of 256; slot 0 is open after reset and an allocate on an empty
// list opens the next slot while the slot_limit register allows it. Free,
// free-to-tail and lookup check that the id lies in an opened slot and is
// allocated, and bad frees are reported and ignored. Each request beat reads
// the link and mark memories when it is accepted and then, once the registered
// read data is back, updates them and the list registers in the execute state.
// A new request is taken while the previous result beat still waits, and the
// block stalls in the update cycle only when that result is not yet taken.
// After reset a clearing pass over all 4096 entries initializes both memories,
// during which no request is accepted; register writes are taken at any time.
module slab_free_list_id_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    slfa_req_if.sink                        i_req,
    slfa_rsp_if.source                      o_rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [slfa_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [slfa_pkg::APB_DATA_W-1:0] pwdata,
    output logic [slfa_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    logic [slfa_pkg::LIMIT_W-1:0] slot_limit;
    slfa_pkg::t_mem_ctl           link_ctl;
    slfa_pkg::t_mem_ctl           mark_ctl;
    logic [slfa_pkg::ID_W-1:0]    link_wr_data;
    logic [slfa_pkg::ID_W-1:0]    link_rd_data;
    logic                         mark_wr_data;
    logic                         mark_rd_data;

    slfa_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_slot_limit (slot_limit)
    );

    slfa_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_slot_limit   (slot_limit),
        .i_req          (i_req),
        .o_rsp          (o_rsp),
        .o_link_ctl     (link_ctl),
        .o_link_wr_data (link_wr_data),
        .i_link_rd_data (link_rd_data),
        .o_mark_ctl     (mark_ctl),
        .o_mark_wr_data (mark_wr_data),
        .i_mark_rd_data (mark_rd_data)
    );

    slfa_ram #(
        .DATA_W (slfa_pkg::ID_W),
        .ADDR_W (slfa_pkg::ID_W)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_rd_en   (link_ctl.rd_en),
        .i_rd_addr (link_ctl.rd_addr),
        .o_rd_data (link_rd_data),
        .i_wr_en   (link_ctl.wr_en),
        .i_wr_addr (link_ctl.wr_addr),
        .i_wr_data (link_wr_data)
    );

    slfa_ram #(
        .DATA_W (1),
        .ADDR_W (slfa_pkg::ID_W)
    ) u_mark_ram (
        .i_clk     (i_clk),
        .i_rd_en   (mark_ctl.rd_en),
        .i_rd_addr (mark_ctl.rd_addr),
        .o_rd_data (mark_rd_data),
        .i_wr_en   (mark_ctl.wr_en),
        .i_wr_addr (mark_ctl.wr_addr),
        .i_wr_data (mark_wr_data)
    );

endmodule

>>> rtl/slfa_ram.sv
// Simple dual-port synchronous RAM with registered read.
module slfa_ram #(
    parameter int DATA_W = slfa_pkg::ID_W,
    parameter int ADDR_W = slfa_pkg::ID_W
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/slfa_cfg.sv
// APB register block holding the slot limit.
module slfa_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [slfa_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [slfa_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [slfa_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [slfa_pkg::LIMIT_W-1:0]        o_slot_limit
);

    logic [slfa_pkg::LIMIT_W-1:0] r_slot_limit;
    logic                         wr_hit;

    assign wr_hit = psel && penable && pwrite && (paddr == slfa_pkg::ADDR_SLOT_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_limit <= slfa_pkg::LIMIT_W'(1);
        end else if (wr_hit) begin
            r_slot_limit <= pwdata[slfa_pkg::LIMIT_W-1:0];
        end
    end

    always_comb begin
        if (paddr == slfa_pkg::ADDR_SLOT_LIMIT) begin
            prdata = slfa_pkg::APB_DATA_W'(r_slot_limit);
        end else begin
            prdata = '0;
        end
    end

    assign pready       = 1'b1;
    assign o_slot_limit = r_slot_limit;

endmodule

>>> rtl/slfa_ctrl.sv
// Sequencer: list registers, read-modify-write of the link and mark memories.
module slfa_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [slfa_pkg::LIMIT_W-1:0]  i_slot_limit,
    slfa_req_if.sink                      i_req,
    slfa_rsp_if.source                    o_rsp,
    output slfa_pkg::t_mem_ctl            o_link_ctl,
    output logic [slfa_pkg::ID_W-1:0]     o_link_wr_data,
    input  logic [slfa_pkg::ID_W-1:0]     i_link_rd_data,
    output slfa_pkg::t_mem_ctl            o_mark_ctl,
    output logic                          o_mark_wr_data,
    input  logic                          i_mark_rd_data
);

    localparam int ID_W    = slfa_pkg::ID_W;
    localparam int SLOT_W  = slfa_pkg::SLOT_W;
    localparam int NSLOT_W = slfa_pkg::NSLOT_W;

    slfa_pkg::t_state  r_state, n_state;
    logic [ID_W-1:0]   r_clr_cnt;
    slfa_pkg::t_op     r_op;
    logic [ID_W-1:0]   r_id;
    logic [ID_W-1:0]   r_head, n_head;
    logic [ID_W-1:0]   r_tail, n_tail;
    logic              r_empty, n_empty;
    logic [NSLOT_W-1:0] r_slots_open, n_slots_open;

    logic              r_out_valid;
    slfa_pkg::t_status r_out_status, n_out_status;
    logic [ID_W-1:0]   r_out_id, n_out_id;

    logic              accept;
    logic              exec_done;
    logic [NSLOT_W-1:0] eff_limit;
    logic              open_slot;
    logic [ID_W-1:0]   slot_base;
    logic              id_in_open;
    slfa_pkg::t_status chk_status;

    assign accept    = i_req.valid && i_req.ready;
    assign exec_done = (r_state == slfa_pkg::S_EXEC) && (!r_out_valid || o_rsp.ready);

    // The configured limit is capped at the slots that exist.
    assign eff_limit  = (i_slot_limit > NSLOT_W'(slfa_pkg::SLOT_CAP)) ?
                        NSLOT_W'(slfa_pkg::SLOT_CAP) : NSLOT_W'(i_slot_limit);
    assign open_slot  = r_empty && (r_slots_open < eff_limit);
    assign slot_base  = {r_slots_open[ID_W-SLOT_W-1:0], SLOT_W'(0)};
    assign id_in_open = {1'b0, r_id[ID_W-1:SLOT_W]} < r_slots_open;

    always_comb begin
        if (!id_in_open) begin
            chk_status = slfa_pkg::ST_OUTSIDE;
        end else if (!i_mark_rd_data) begin
            chk_status = slfa_pkg::ST_NOT_ALLOC;
        end else begin
            chk_status = slfa_pkg::ST_OK;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            slfa_pkg::S_CLEAR: begin
                if (r_clr_cnt == '1) begin
                    n_state = slfa_pkg::S_IDLE;
                end
            end
            slfa_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = slfa_pkg::S_EXEC;
                end
            end
            slfa_pkg::S_EXEC: begin
                if (exec_done) begin
                    n_state = slfa_pkg::S_IDLE;
                end
            end
            default: n_state = slfa_pkg::S_CLEAR;
        endcase
    end

    // Outputs: memory accesses, list updates and the result.
    always_comb begin
        i_req.ready    = (r_state == slfa_pkg::S_IDLE);

        o_link_ctl         = '0;
        o_link_ctl.rd_en   = accept;
        o_link_ctl.rd_addr = r_head;
        o_link_wr_data     = '0;
        o_mark_ctl         = '0;
        o_mark_ctl.rd_en   = accept;
        o_mark_ctl.rd_addr = i_req.node_id;
        o_mark_wr_data     = 1'b0;

        n_head       = r_head;
        n_tail       = r_tail;
        n_empty      = r_empty;
        n_slots_open = r_slots_open;
        n_out_status = slfa_pkg::ST_OK;
        n_out_id     = r_id;

        case (r_state)
            slfa_pkg::S_CLEAR: begin
                o_link_ctl.wr_en   = 1'b1;
                o_link_ctl.wr_addr = r_clr_cnt;
                o_link_wr_data     = r_clr_cnt + ID_W'(1);
                o_mark_ctl.wr_en   = 1'b1;
                o_mark_ctl.wr_addr = r_clr_cnt;
            end
            slfa_pkg::S_EXEC: begin
                if (r_op == slfa_pkg::OP_ALLOC) begin
                    if (open_slot) begin
                        // Links of an unopened slot still hold their ascending reset chain.
                        n_out_id           = slot_base;
                        o_mark_ctl.wr_en   = exec_done;
                        o_mark_ctl.wr_addr = slot_base;
                        o_mark_wr_data     = 1'b1;
                        n_head             = slot_base + ID_W'(1);
                        n_tail             = slot_base + ID_W'(slfa_pkg::SLOT_SIZE - 1);
                        n_empty            = 1'b0;
                        n_slots_open       = r_slots_open + NSLOT_W'(1);
                    end else if (r_empty) begin
                        n_out_status = slfa_pkg::ST_NO_FREE;
                        n_out_id     = '0;
                    end else begin
                        n_out_id           = r_head;
                        o_mark_ctl.wr_en   = exec_done;
                        o_mark_ctl.wr_addr = r_head;
                        o_mark_wr_data     = 1'b1;
                        if (r_head == r_tail) begin
                            n_empty = 1'b1;
                        end else begin
                            n_head = i_link_rd_data;
                        end
                    end
                end else begin
                    n_out_status = chk_status;
                    if (chk_status == slfa_pkg::ST_OK && r_op != slfa_pkg::OP_LOOKUP) begin
                        o_mark_ctl.wr_en   = exec_done;
                        o_mark_ctl.wr_addr = r_id;
                        if (r_empty) begin
                            n_head  = r_id;
                            n_tail  = r_id;
                            n_empty = 1'b0;
                        end else if (r_op == slfa_pkg::OP_FREE_HEAD) begin
                            o_link_ctl.wr_en   = exec_done;
                            o_link_ctl.wr_addr = r_id;
                            o_link_wr_data     = r_head;
                            n_head             = r_id;
                        end else begin
                            o_link_ctl.wr_en   = exec_done;
                            o_link_ctl.wr_addr = r_tail;
                            o_link_wr_data     = r_id;
                            n_tail             = r_id;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= slfa_pkg::S_CLEAR;
            r_clr_cnt    <= '0;
            r_head       <= '0;
            r_tail       <= ID_W'(slfa_pkg::SLOT_SIZE - 1);
            r_empty      <= 1'b0;
            r_slots_open <= NSLOT_W'(1);
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == slfa_pkg::S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + ID_W'(1);
            end
            if (exec_done) begin
                r_head       <= n_head;
                r_tail       <= n_tail;
                r_empty      <= n_empty;
                r_slots_open <= n_slots_open;
                r_out_valid  <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= slfa_pkg::t_op'(i_req.op);
            r_id <= i_req.node_id;
        end
        if (exec_done) begin
            r_out_status <= n_out_status;
            r_out_id     <= n_out_id;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.result_id = r_out_id;

    a_head_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != slfa_pkg::S_CLEAR && !r_empty)
        |-> ({1'b0, r_head[ID_W-1:SLOT_W]} < r_slots_open))
        else $error("list head outside the opened slots");

    a_tail_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != slfa_pkg::S_CLEAR && !r_empty)
        |-> ({1'b0, r_tail[ID_W-1:SLOT_W]} < r_slots_open))
        else $error("list tail outside the opened slots");

    a_slots_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slots_open != '0) && (r_slots_open <= NSLOT_W'(slfa_pkg::SLOT_CAP)))
        else $error("open slot count out of range");

    a_rsp_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == slfa_pkg::S_EXEC))
        else $error("result beat raised outside the execute step");

    a_exec_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_done |=> (r_state == slfa_pkg::S_IDLE) && r_out_valid)
        else $error("execute step did not deliver its result");

endmodule

>>> verif/slfa_tb_pkg.sv
// Scoreboard class that predicts and checks the allocator's response beats.
`timescale 1ns / 1ps
package slfa_check_pkg;
    import slfa_pkg::*;

    typedef struct {
        t_status         status;
        logic [ID_W-1:0] result_id;
    } t_alloc_result;

    class id_alloc_scoreboard;
        logic [ID_W-1:0]    link_mem [ID_SPACE];
        bit                 alloc_mark [ID_SPACE];
        logic [ID_W-1:0]    head_id;
        logic [ID_W-1:0]    tail_id;
        bit                 list_is_empty;
        int                 open_slots;
        int                 slot_limit;
        logic [ID_W-1:0]    held_ids [$];
        t_alloc_result      expected_results [$];
        int                 errors;

        function new();
            for (int i = 0; i < ID_SPACE; i++) begin
                link_mem[i]   = ID_W'(i + 1);
                alloc_mark[i] = 1'b0;
            end
            head_id       = '0;
            tail_id       = ID_W'(SLOT_SIZE - 1);
            list_is_empty = 1'b0;
            open_slots    = 1;
            slot_limit    = 1;
            errors        = 0;
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR: %s", msg);
        endtask

        function void set_limit(logic [LIMIT_W-1:0] value);
            slot_limit = int'(value);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function int held_count();
            return held_ids.size();
        endfunction

        function logic [ID_W-1:0] pick_held();
            return held_ids[$urandom_range(0, held_ids.size() - 1)];
        endfunction

        function int opened_span();
            return open_slots * SLOT_SIZE;
        endfunction

        function void drop_held(logic [ID_W-1:0] id);
            for (int i = 0; i < held_ids.size(); i++) begin
                if (held_ids[i] == id) begin
                    held_ids.delete(i);
                    return;
                end
            end
        endfunction

        // Applies one accepted request beat to the predicted state.
        function void note_request(t_op op, logic [ID_W-1:0] id);
            t_alloc_result   res;
            int              lim;
            int              base;
            res.status    = ST_OK;
            res.result_id = id;
            if (op == OP_ALLOC) begin
                lim = (slot_limit > SLOT_CAP) ? SLOT_CAP : slot_limit;
                if (list_is_empty && open_slots < lim) begin
                    base = open_slots * SLOT_SIZE;
                    for (int k = 0; k < SLOT_SIZE - 1; k++)
                        link_mem[ID_W'(base + k)] = ID_W'(base + k + 1);
                    head_id       = ID_W'(base);
                    tail_id       = ID_W'(base + SLOT_SIZE - 1);
                    list_is_empty = 1'b0;
                    open_slots++;
                end
                if (list_is_empty) begin
                    res.status    = ST_NO_FREE;
                    res.result_id = '0;
                end else begin
                    res.result_id       = head_id;
                    alloc_mark[head_id] = 1'b1;
                    held_ids.push_back(head_id);
                    if (head_id == tail_id)
                        list_is_empty = 1'b1;
                    else
                        head_id = link_mem[head_id];
                end
            end else begin
                if (int'(id >> SLOT_W) >= open_slots)
                    res.status = ST_OUTSIDE;
                else if (!alloc_mark[id])
                    res.status = ST_NOT_ALLOC;
                if (res.status == ST_OK && op != OP_LOOKUP) begin
                    alloc_mark[id] = 1'b0;
                    drop_held(id);
                    if (list_is_empty) begin
                        head_id       = id;
                        tail_id       = id;
                        list_is_empty = 1'b0;
                    end else if (op == OP_FREE_HEAD) begin
                        link_mem[id] = head_id;
                        head_id      = id;
                    end else begin
                        link_mem[tail_id] = id;
                        tail_id           = id;
                    end
                end
            end
            expected_results.push_back(res);
        endfunction

        task check_response(logic [1:0] status, logic [ID_W-1:0] result_id);
            t_alloc_result exp_res;
            if (expected_results.size() == 0) begin
                report($sformatf("response beat with nothing pending: status %0d id %0d",
                                 status, result_id));
                return;
            end
            exp_res = expected_results.pop_front();
            if (status !== exp_res.status)
                report($sformatf("status %0d, expected %0d", status, exp_res.status));
            if (result_id !== exp_res.result_id)
                report($sformatf("result_id %0d, expected %0d", result_id,
                                 exp_res.result_id));
        endtask
    endclass

endpackage

>>> verif/tb_slab_free_list_id_allocator.sv
// Top-level testbench of the slab free-list id allocator.
`timescale 1ns / 1ps
module tb_slab_free_list_id_allocator;
    import slfa_pkg::*;
    import slfa_check_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    slfa_req_if req_if ();
    slfa_rsp_if rsp_if ();

    id_alloc_scoreboard sb = new();

    bit idle_en  = 1'b1;
    int hold_len = 0;
    int hold_left = 0;

    slab_free_list_id_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    // Response side: random stalls, plus a long hold-off counted here on request.
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid && rsp_if.ready)
                sb.check_response(rsp_if.status, rsp_if.result_id);
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (hold_len > 0) begin
                hold_left = hold_len - 1;
                hold_len  = 0;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= !(idle_en && $urandom_range(0, 99) < 32);
            end
        end
    end

    task automatic send_req(t_op op, logic [ID_W-1:0] id);
        int gap;
        gap = (idle_en && $urandom_range(0, 99) < 32) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.op      <= op;
        req_if.node_id <= id;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(op, id);
    endtask

    task automatic wait_drained();
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Register write followed by a read-back of the same register.
    task automatic set_slot_limit(logic [LIMIT_W-1:0] value);
        req_if.valid <= 1'b0;
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SLOT_LIMIT;
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_limit(value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DATA_W'(value))
            sb.report($sformatf("slot_limit reads %0d, written %0d", prdata, value));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mostly well-formed traffic: frees and lookups aim at held ids.
    task automatic run_traffic(int count, int alloc_pct);
        t_op             op;
        logic [ID_W-1:0] id;
        int              pick;
        for (int n = 0; n < count; n++) begin
            id = ID_W'($urandom);
            if ($urandom_range(0, 99) < alloc_pct) begin
                op = OP_ALLOC;
            end else begin
                pick = $urandom_range(0, 9);
                op = (pick < 4) ? OP_FREE_HEAD : (pick < 8) ? OP_FREE_TAIL : OP_LOOKUP;
                pick = $urandom_range(0, 99);
                if (pick < 85 && sb.held_count() > 0)
                    id = sb.pick_held();
                else if (pick < 93)
                    id = ID_W'($urandom_range(0, sb.opened_span() - 1));
            end
            send_req(op, id);
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.op      <= OP_ALLOC;
        req_if.node_id <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: bad ids, double free, both free ends, field extremes.
        send_req(OP_LOOKUP,    12'h000);
        send_req(OP_LOOKUP,    12'hFFF);
        send_req(OP_FREE_HEAD, 12'h100);
        send_req(OP_FREE_TAIL, 12'h000);
        send_req(OP_ALLOC,     12'hFFF);
        send_req(OP_ALLOC,     12'h000);
        send_req(OP_LOOKUP,    12'h000);
        send_req(OP_FREE_TAIL, 12'h000);
        send_req(OP_FREE_TAIL, 12'h000);
        send_req(OP_FREE_HEAD, 12'h001);
        send_req(OP_FREE_HEAD, 12'h001);
        send_req(OP_ALLOC,     12'hAAA);
        send_req(OP_ALLOC,     12'h555);
        send_req(OP_LOOKUP,    12'h0FF);
        send_req(OP_FREE_HEAD, 12'h0FF);
        send_req(OP_FREE_TAIL, 12'hFFF);
        send_req(OP_LOOKUP,    12'hAAA);
        send_req(OP_LOOKUP,    12'h055);
        send_req(OP_FREE_TAIL, 12'h002);
        send_req(OP_ALLOC,     12'h000);

        // One slot only: exhaust it, free into the empty list, and back up
        // the block with a long response hold-off.
        set_slot_limit(5'd1);
        hold_len = 300;
        run_traffic(330, 92);

        // A second slot opens on demand; this phase runs without idling.
        set_slot_limit(5'd2);
        idle_en = 1'b0;
        run_traffic(150, 55);
        idle_en = 1'b1;

        // Zero acts like one and closes nothing already open.
        set_slot_limit(5'd0);
        run_traffic(150, 45);

        // Above the cap, then exactly at it with free-heavy traffic.
        set_slot_limit(5'd31);
        run_traffic(200, 85);
        set_slot_limit(5'd16);
        run_traffic(200, 30);

        req_if.valid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
rtl/slfa_pkg.sv
rtl/slfa_ifs.sv
rtl/slfa_ram.sv
rtl/slfa_cfg.sv
rtl/slfa_ctrl.sv
rtl/slab_free_list_id_allocator.sv
verif/slfa_tb_pkg.sv
verif/tb_slab_free_list_id_allocator.sv
